// ===== rtl/button_debounce_quadrature_knob_core_defines.svh =====
// Assertion macros for the knob/button core.
// Expects clk and rst in the scope where the macros are used.
`ifndef BUTTON_DEBOUNCE_QUADRATURE_KNOB_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_QUADRATURE_KNOB_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDQK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDQK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdqk_pkg.sv =====
// Shared types and constants for the knob/button core.
// No dependencies.
`default_nettype none
package bdqk_pkg;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 8;
  localparam int unsigned STEP_W = 8;
  localparam int unsigned DIV_W = 8;
  localparam logic [DIV_W-1:0] TICK_DIVIDE_RESET = 8'd9;

  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_TAKE_NEG = 2'd1;
  localparam logic [1:0] MODE_TAKE_POS = 2'd2;

  localparam logic [1:0] QUAD_RESET = 2'b11;

  typedef struct packed {
    logic                     key_down;
    logic                     step_taken;
    logic signed [STEP_W-1:0] step_count;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/button_debounce_quadrature_knob_core.sv =====
// Each accepted input word gives one registered result word. One word per cycle while the
// skid register is empty; a two-entry output buffer (output register plus skid register)
// keeps the input open while one finished word waits downstream.
// Reset (synchronous): debouncer released, prescaler and step counter zero,
// last quadrature sample both-high, tick_divide back to 9, output buffer empty.
`default_nettype none
`include "button_debounce_quadrature_knob_core_defines.svh"
module button_debounce_quadrature_knob_core
  import bdqk_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire  logic                     clk,
  input  wire  logic                     rst,
  // configuration
  input  wire  logic                     cfg_valid,
  output logic                           cfg_ready,
  input  wire  logic [DIV_W-1:0]         cfg_data,
  // input words
  input  wire  logic                     in_valid,
  output logic                           in_ready,
  input  wire  logic [1:0]               mode,
  input  wire  logic                     button_level,
  input  wire  logic                     chan_a,
  input  wire  logic                     chan_b,
  // result words
  output logic                           out_valid,
  input  wire  logic                     out_ready,
  output logic                           key_down,
  output logic                           step_taken,
  output logic signed [STEP_W-1:0]       step_count
);

  typedef enum logic [1:0] {
    DB_RELEASED  = 2'd0,
    DB_PRESSING  = 2'd1,
    DB_PRESSED   = 2'd2,
    DB_RELEASING = 2'd3
  } db_state_t;

  localparam logic signed [COUNT_WIDTH-1:0] CntMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CntMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

  // state
  logic [DIV_W-1:0]              tick_divide;
  logic [DIV_W-1:0]              prescale_count, prescale_count_next;
  db_state_t                     db_state, db_state_next;
  logic [1:0]                    last_quad, last_quad_next;
  logic signed [COUNT_WIDTH-1:0] pending_steps, pending_steps_next;

  // output buffer
  result_t out_word, skid_word, result_next;
  logic    skid_valid;

  logic push, pop;
  logic pressed_now;
  logic [1:0] quad_now;
  logic step_up, step_dn;
  logic taken;
  logic take_pos_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  assign pressed_now = !button_level;
  assign quad_now    = {chan_b, chan_a};

  // Gray step direction from the last {B,A} sample; a double step counts as none.
  always_comb begin
    step_up = 1'b0;
    step_dn = 1'b0;
    unique case (last_quad)
      2'd0: begin
        step_dn = (quad_now == 2'd1);
        step_up = (quad_now == 2'd2);
      end
      2'd1: begin
        step_up = (quad_now == 2'd0);
        step_dn = (quad_now == 2'd3);
      end
      2'd2: begin
        step_dn = (quad_now == 2'd0);
        step_up = (quad_now == 2'd3);
      end
      default: begin
        step_up = (quad_now == 2'd1);
        step_dn = (quad_now == 2'd2);
      end
    endcase
  end

  always_comb begin
    prescale_count_next = prescale_count;
    db_state_next       = db_state;
    last_quad_next      = last_quad;
    pending_steps_next  = pending_steps;
    taken               = 1'b0;
    unique case (mode)
      MODE_TICK: begin
        if (prescale_count < tick_divide) begin
          prescale_count_next = prescale_count + DIV_W'(1);
        end else begin
          prescale_count_next = '0;
          unique case (db_state)
            DB_RELEASED:  db_state_next = pressed_now ? DB_PRESSING : DB_RELEASED;
            DB_PRESSING:  db_state_next = pressed_now ? DB_PRESSED  : DB_RELEASED;
            DB_PRESSED:   db_state_next = pressed_now ? DB_PRESSED  : DB_RELEASING;
            DB_RELEASING: db_state_next = pressed_now ? DB_PRESSED  : DB_RELEASED;
            default:      db_state_next = DB_RELEASED;
          endcase
        end
        last_quad_next = quad_now;
        // saturate instead of wrapping
        if (step_up && pending_steps != CntMax) begin
          pending_steps_next = pending_steps + CntOne;
        end else if (step_dn && pending_steps != CntMin) begin
          pending_steps_next = pending_steps - CntOne;
        end
      end
      MODE_TAKE_NEG: begin
        if (pending_steps < 0) begin
          pending_steps_next = pending_steps + CntOne;
          taken              = 1'b1;
        end
      end
      MODE_TAKE_POS: begin
        if (pending_steps > 0) begin
          pending_steps_next = pending_steps - CntOne;
          taken              = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_next.key_down   = (db_state_next == DB_PRESSED) ||
                             (db_state_next == DB_RELEASING);
    result_next.step_taken = taken;
    // sign-extends or truncates to the port width
    result_next.step_count = STEP_W'(pending_steps_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide    <= TICK_DIVIDE_RESET;
      prescale_count <= '0;
      db_state       <= DB_RELEASED;
      last_quad      <= QUAD_RESET;
      pending_steps  <= '0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tick_divide <= cfg_data;
      end
      if (push) begin
        prescale_count <= prescale_count_next;
        db_state       <= db_state_next;
        last_quad      <= last_quad_next;
        pending_steps  <= pending_steps_next;
      end
      // two-entry output buffer; no push while the skid entry is full
      if (pop) begin
        if (skid_valid) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end else if (push) begin
          out_word <= result_next;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid) begin
          skid_word  <= result_next;
          skid_valid <= 1'b1;
        end else begin
          out_word  <= result_next;
          out_valid <= 1'b1;
        end
      end
    end
  end

  assign key_down   = out_word.key_down;
  assign step_taken = out_word.step_taken;
  assign step_count = out_word.step_count;

  assign take_pos_hit = push && (mode == MODE_TAKE_POS) && (pending_steps > 0);

  `BDQK_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid && !in_ready, "lone skid word")
  `BDQK_ASSERT_NEXT(a_idle_hold, !push, $stable(pending_steps) && $stable(db_state), "state moved")
  `BDQK_ASSERT_NEXT(a_take_pos, take_pos_hit, pending_steps + CntOne == $past(pending_steps), "no decrement")

endmodule
`default_nettype wire

// ===== bench/tb_button_debounce_quadrature_knob_core.sv =====
// Testbench for button_debounce_quadrature_knob_core: directed and random words on
// valid/ready channels, checked against a cycle-free predictor of the knob and button.
// Depends on bdqk_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_button_debounce_quadrature_knob_core;
  import bdqk_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH_DEFAULT;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [CW-1:0] STEP_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] STEP_LO = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] STEP_ONE = CW'(1);

  typedef enum logic [1:0] {DB_RELEASED, DB_ARMING, DB_HELD, DB_LETTING_GO} deb_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [DIV_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] mode = MODE_TICK;
  logic button_level = 1'b1;
  logic chan_a = 1'b1;
  logic chan_b = 1'b1;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid;
  logic key_down, step_taken;
  logic signed [STEP_W-1:0] step_count;

  // predictor state
  logic [DIV_W-1:0] tick_div;
  logic [7:0] presc_cnt;
  deb_state_t deb_st;
  logic [1:0] prev_quad;
  logic signed [CW-1:0] step_acc;

  result_t knob_results_due[$];
  result_t due_word;

  // stimulus side
  logic [1:0] stim_quad = QUAD_RESET;
  bit tx_gaps_on = 1'b1;
  logic rx_stalls_on = 1'b1;
  logic hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned in_stalls = 0;
  int unsigned fail_count = 0;

  button_debounce_quadrature_knob_core #(.COUNT_WIDTH(CW)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .button_level  (button_level),
    .chan_a        (chan_a),
    .chan_b        (chan_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_down      (key_down),
    .step_taken    (step_taken),
    .step_count    (step_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void reset_knob_model();
    tick_div = TICK_DIVIDE_RESET;
    presc_cnt = '0;
    deb_st = DB_RELEASED;
    prev_quad = QUAD_RESET;
    step_acc = '0;
  endfunction

  // Applies one accepted word to the predictor state and returns the result it yields.
  function automatic result_t advance_knob(input logic [1:0] md, input logic btn_lvl,
                                           input logic a, input logic b);
    logic pressed;
    logic [1:0] now;
    int dir;
    result_t r;
    pressed = ~btn_lvl;
    now = {b, a};
    dir = 0;
    r.step_taken = 1'b0;
    case (md)
      MODE_TICK: begin
        if (presc_cnt < tick_div) begin
          presc_cnt = presc_cnt + 8'd1;
        end else begin
          presc_cnt = '0;
          case (deb_st)
            DB_RELEASED:   deb_st = pressed ? DB_ARMING : DB_RELEASED;
            DB_ARMING:     deb_st = pressed ? DB_HELD : DB_RELEASED;
            DB_HELD:       deb_st = pressed ? DB_HELD : DB_LETTING_GO;
            DB_LETTING_GO: deb_st = pressed ? DB_HELD : DB_RELEASED;
          endcase
        end
        case (prev_quad)
          2'd0: dir = (now == 2'd1) ? -1 : (now == 2'd2) ? 1 : 0;
          2'd1: dir = (now == 2'd0) ? 1 : (now == 2'd3) ? -1 : 0;
          2'd2: dir = (now == 2'd0) ? -1 : (now == 2'd3) ? 1 : 0;
          2'd3: dir = (now == 2'd1) ? 1 : (now == 2'd2) ? -1 : 0;
        endcase
        if (dir > 0 && step_acc != STEP_HI) step_acc = step_acc + STEP_ONE;
        else if (dir < 0 && step_acc != STEP_LO) step_acc = step_acc - STEP_ONE;
        prev_quad = now;
      end
      MODE_TAKE_NEG: begin
        if (step_acc < 0) begin
          step_acc = step_acc + STEP_ONE;
          r.step_taken = 1'b1;
        end
      end
      MODE_TAKE_POS: begin
        if (step_acc > 0) begin
          step_acc = step_acc - STEP_ONE;
          r.step_taken = 1'b1;
        end
      end
      default: ;
    endcase
    r.key_down = (deb_st == DB_HELD || deb_st == DB_LETTING_GO);
    r.step_count = step_acc[STEP_W-1:0];
    return r;
  endfunction

  // One Gray step of the knob from cur, clockwise when up.
  function automatic logic [1:0] gray_step(input logic [1:0] cur, input bit up);
    case (cur)
      2'd0: return up ? 2'd2 : 2'd1;
      2'd1: return up ? 2'd0 : 2'd3;
      2'd2: return up ? 2'd3 : 2'd0;
      default: return up ? 2'd1 : 2'd2;
    endcase
  endfunction

  // in_valid is only lowered ahead of a gap, so back-to-back words keep it high.
  task automatic send_word(input logic [1:0] md, input logic btn_lvl,
                           input logic a, input logic b);
    int unsigned gap;
    gap = 0;
    if (tx_gaps_on && $urandom_range(0, 99) < 25) gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    button_level <= btn_lvl;
    chan_a <= a;
    chan_b <= b;
    @(posedge clk);
    while (!in_ready) begin
      in_stalls++;
      @(posedge clk);
    end
    knob_results_due.push_back(advance_knob(md, btn_lvl, a, b));
    if (md == MODE_TICK) stim_quad = {b, a};
    words_sent++;
  endtask

  task automatic send_tick(input logic btn_lvl, input logic [1:0] quad);
    send_word(MODE_TICK, btn_lvl, quad[0], quad[1]);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (knob_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tick_divide(input logic [DIV_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tick_div = value;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 64;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_stalls_on && $urandom_range(0, 99) < 20) stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (knob_results_due.size() == 0) begin
        $error("unexpected result word: key_down=%0b step_taken=%0b step_count=%0d",
               key_down, step_taken, step_count);
        fail_count++;
      end else begin
        due_word = knob_results_due.pop_front();
        if (key_down !== due_word.key_down) begin
          $error("key_down: expected %0b, got %0b", due_word.key_down, key_down);
          fail_count++;
        end
        if (step_taken !== due_word.step_taken) begin
          $error("step_taken: expected %0b, got %0b", due_word.step_taken, step_taken);
          fail_count++;
        end
        if (step_count !== due_word.step_count) begin
          $error("step_count: expected %0d, got %0d", due_word.step_count, step_count);
          fail_count++;
        end
        words_checked++;
      end
    end
  end

  // Nothing pending after reset: takes find no step, unused mode changes nothing.
  task automatic test_reset_state();
    send_word(MODE_UNUSED, 1'b0, 1'b0, 1'b0);
    send_word(MODE_TAKE_NEG, 1'b0, 1'b1, 1'b0);
    send_word(MODE_TAKE_POS, 1'b1, 1'b0, 1'b1);
  endtask

  // Walks every one of the 16 previous/current channel pairs once, starting from reset.
  task automatic test_quadrature_steps();
    logic [1:0] walk [16] = '{2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd3,
                             2'd1, 2'd3, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
    foreach (walk[i]) send_tick(1'b1, walk[i]);
  endtask

  // Divider at zero so every tick moves the debouncer through each transition.
  task automatic test_button_debounce();
    logic lvl [10] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    drain_idle();
    write_tick_divide('0);
    foreach (lvl[i]) send_tick(lvl[i], stim_quad);
  endtask

  // Spins the knob into both rails at the slowest divider, then lowers the divider
  // while the prescaler sits above the new value.
  task automatic test_step_saturation();
    drain_idle();
    write_tick_divide('1);
    repeat (130) send_tick(1'b0, gray_step(stim_quad, 1'b1));
    send_word(MODE_TAKE_POS, 1'b1, 1'b1, 1'b1);
    send_word(MODE_TAKE_NEG, 1'b0, 1'b0, 1'b0);
    repeat (258) send_tick(1'b1, gray_step(stim_quad, 1'b0));
    repeat (2) send_word(MODE_TAKE_NEG, 1'b1, 1'b0, 1'b1);
    send_word(MODE_TAKE_POS, 1'b0, 1'b1, 1'b0);
    drain_idle();
    write_tick_divide(8'd4);
    repeat (6) send_tick(1'b0, stim_quad);
  endtask

  // Receiver holds off while the sender keeps offering words back to back.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_req <= 1'b1;
    repeat (12) send_tick(rand_bit(), gray_step(stim_quad, 1'b1));
    tx_gaps_on = 1'b1;
  endtask

  // Mostly steady rotation with a slowly changing button; some noise and takes.
  task automatic test_random_knob();
    logic [DIV_W-1:0] divs [4];
    bit up;
    logic btn_hold;
    int unsigned r;
    divs = '{8'd1, DIV_W'($urandom_range(2, 254)), 8'd3, DIV_W'($urandom_range(0, 255))};
    up = 1'b1;
    btn_hold = 1'b1;
    foreach (divs[p]) begin
      drain_idle();
      write_tick_divide(divs[p]);
      tx_gaps_on = (p != 1);
      rx_stalls_on <= (p != 1);
      repeat (12) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 8) up = ~up;
        if ($urandom_range(0, 99) < 4) btn_hold = ~btn_hold;
        if (r < 55) begin
          // occasional bounce on the button pin
          send_tick(($urandom_range(0, 9) == 0) ? ~btn_hold : btn_hold,
                    gray_step(stim_quad, up));
        end else if (r < 62) begin
          send_tick(btn_hold, stim_quad);
        end else if (r < 72) begin
          send_word(MODE_TICK, rand_bit(), rand_bit(), rand_bit());
        end else if (r < 94) begin
          send_word($urandom_range(0, 1) ? MODE_TAKE_NEG : MODE_TAKE_POS,
                    rand_bit(), rand_bit(), rand_bit());
        end else begin
          send_word(MODE_UNUSED, rand_bit(), rand_bit(), rand_bit());
        end
      end
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on <= 1'b1;
  endtask

  initial begin
    reset_knob_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_quadrature_steps();
    test_button_debounce();
    test_step_saturation();
    test_backpressure();
    test_random_knob();
    drain_idle();
    $display("run: %0d words sent, %0d results checked, %0d tick_divide writes",
             words_sent, words_checked, cfg_writes);
    $display("run: input stalled for %0d cycles under output backpressure", in_stalls);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bdqk_pkg.sv
rtl/button_debounce_quadrature_knob_core.sv
bench/tb_button_debounce_quadrature_knob_core.sv
